>>> hw/rtl/npt_pkg.sv
package npt_pkg;

   localparam int SLOTS    = 8;
   localparam int NAME_LEN = 64;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(NAME_LEN);
   localparam int USED_W = 3;

   typedef struct packed {
      logic        kind;
      logic [7:0]  name_char;
      logic [31:0] offset_in;
   } npt_req_type;

   typedef struct packed {
      logic              name_ok;
      logic              found;
      logic [31:0]       offset_out;
      logic [USED_W-1:0] slot_used;
   } npt_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // request taken this cycle
      logic rd;         // read both name stores at the scan index
      logic cmp_phase;  // registered read data feeds the slot compare
      logic wr_phase;   // registered read data is copied into the chosen slot
      logic decide;     // pick the slot, build the result
      logic load_rsp;   // move result into the output register
   } npt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic term;       // request carries the terminating zero
      logic term_ok;    // name collected so far is valid
      logic is_update;
      logic rd_last;    // scan index sits on the last character
   } npt_stat_type;

   function automatic logic [USED_W-1:0] slot_to_used(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+USED_W-1:0] w;
      w = {{USED_W{1'b0}}, s};
      return w[USED_W-1:0];
   endfunction

endpackage

>>> hw/rtl/name_keyed_position_table_core.sv
// Characters are taken one per cycle while idle; a non-zero character gives no response.
// Terminating request: an invalid name goes straight to the response register; a lookup
// of an L-character name scans the stores (one memory read per character, all slots in
// parallel), then decides; an update then copies the name into the chosen slot as well.
// The next request is taken in the cycle after the response register loads.
// Synchronous active-high reset empties every slot and zeroes the pointer.
module name_keyed_position_table_core
   import npt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  npt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output npt_rsp_type rsp_data
);

   npt_cmd_type  cmd;
   npt_stat_type stat;

   npt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   npt_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // invalid names leave every other field zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.name_ok |->
         !rsp_data.found && rsp_data.slot_used == '0 && rsp_data.offset_out == '0)
      else $error("invalid name gave non-zero result fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.offset_out == '0)
      else $error("offset reported without a hit");

   // no new request while the stores are being scanned or written
   assert property (@(posedge clock) disable iff (reset)
      (cmd.rd || cmd.decide || cmd.wr_phase) |-> !req_ready)
      else $error("request accepted during slot scan");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_rsp))
      else $error("response raised without a load");

endmodule

>>> hw/rtl/npt_ctrl.sv
module npt_ctrl
   import npt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  npt_stat_type stat,
   output npt_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CMP      = 3'd1;
   localparam logic [2:0] ST_CMP_END  = 3'd2;
   localparam logic [2:0] ST_DECIDE   = 3'd3;
   localparam logic [2:0] ST_COPY     = 3'd4;
   localparam logic [2:0] ST_COPY_END = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && stat.term) begin
               state_in = stat.term_ok ? ST_CMP : ST_DONE;
            end
         end
         ST_CMP: begin
            cmd.rd        = 1'b1;
            cmd.cmp_phase = 1'b1;
            if (stat.rd_last) begin
               state_in = ST_CMP_END;
            end
         end
         ST_CMP_END: begin
            cmd.cmp_phase = 1'b1;
            state_in      = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.is_update ? ST_COPY : ST_DONE;
         end
         ST_COPY: begin
            cmd.rd       = 1'b1;
            cmd.wr_phase = 1'b1;
            if (stat.rd_last) begin
               state_in = ST_COPY_END;
            end
         end
         ST_COPY_END: begin
            cmd.wr_phase = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/npt_dpath.sv
module npt_dpath
   import npt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  npt_req_type  req_data,
   input  npt_cmd_type  cmd,
   output npt_stat_type stat,
   output npt_rsp_type  rsp_data
);

   // incoming name and slot names; row i holds character i of every slot's name
   logic [7:0]             inc_mem  [NAME_LEN];
   logic [SLOTS-1:0][7:0]  name_mem [NAME_LEN];
   logic [7:0]             inc_q_ff;
   logic [SLOTS-1:0][7:0]  name_q_ff;

   logic [CNT_W-1:0]  count_ff;
   logic              too_long_ff;
   logic [CNT_W-1:0]  len_ff;
   logic              kind_ff;
   logic [31:0]       offset_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  rd_addr_ff;
   logic              rd_vld_ff;
   logic [SLOTS-1:0]  cand_ff;
   logic [CNT_W-1:0]  slot_len_ff [SLOTS];
   logic [31:0]       slot_off_ff [SLOTS];
   logic [SLOT_W-1:0] ptr_ff;
   logic [SLOT_W-1:0] sel_ff;
   logic              res_ok_ff;
   logic              res_found_ff;
   logic [31:0]       res_off_ff;
   logic [USED_W-1:0] res_used_ff;
   npt_rsp_type       rsp_ff;

   logic              term;
   logic              term_ok;
   logic              room;
   logic              rd_last;
   logic              hit_any;
   logic [SLOT_W-1:0] hit_idx;
   logic              empty_any;
   logic [SLOT_W-1:0] empty_idx;
   logic [SLOT_W-1:0] chosen;
   logic [SLOT_W-1:0] ptr_next;

   assign term    = (req_data.name_char == 8'd0);
   assign term_ok = (count_ff != '0) && !too_long_ff;
   assign room    = (count_ff < CNT_W'(NAME_LEN - 1));
   assign rd_last = (idx_ff == len_ff - 1'b1);

   assign stat.term      = term;
   assign stat.term_ok   = term_ok;
   assign stat.is_update = kind_ff;
   assign stat.rd_last   = rd_last;

   // lowest index wins
   always_comb begin
      hit_any   = 1'b0;
      hit_idx   = '0;
      empty_any = 1'b0;
      empty_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (cand_ff[s]) begin
            hit_any = 1'b1;
            hit_idx = SLOT_W'(s);
         end
         if (slot_len_ff[s] == '0) begin
            empty_any = 1'b1;
            empty_idx = SLOT_W'(s);
         end
      end
   end

   assign ptr_next = (ptr_ff == SLOT_W'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
   assign chosen   = hit_any ? hit_idx : (empty_any ? empty_idx : ptr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         too_long_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
         ptr_ff      <= '0;
         for (int s = 0; s < SLOTS; s++) begin
            slot_len_ff[s] <= '0;
         end
      end else begin
         rd_vld_ff <= cmd.rd;
         if (cmd.accept) begin
            if (term) begin
               count_ff    <= '0;
               too_long_ff <= 1'b0;
            end else if (room) begin
               count_ff <= count_ff + 1'b1;
            end else begin
               too_long_ff <= 1'b1;
            end
         end
         if (cmd.decide && kind_ff) begin
            slot_len_ff[chosen] <= len_ff;
            if (!hit_any && !empty_any) begin
               ptr_ff <= ptr_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !term && room) begin
         inc_mem[count_ff] <= req_data.name_char;
      end
      if (cmd.rd) begin
         inc_q_ff <= inc_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_phase && rd_vld_ff) begin
         name_mem[rd_addr_ff][sel_ff] <= inc_q_ff;
      end
      if (cmd.rd) begin
         name_q_ff <= name_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && term) begin
         len_ff       <= count_ff;
         kind_ff      <= req_data.kind;
         offset_ff    <= req_data.offset_in;
         idx_ff       <= '0;
         res_ok_ff    <= term_ok;
         res_found_ff <= 1'b0;
         res_off_ff   <= '0;
         res_used_ff  <= '0;
         for (int s = 0; s < SLOTS; s++) begin
            cand_ff[s] <= (slot_len_ff[s] == count_ff);
         end
      end
      if (cmd.rd) begin
         rd_addr_ff <= idx_ff;
         idx_ff     <= rd_last ? '0 : idx_ff + 1'b1;
      end
      if (cmd.cmp_phase && rd_vld_ff) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (name_q_ff[s] != inc_q_ff) begin
               cand_ff[s] <= 1'b0;
            end
         end
      end
      if (cmd.decide) begin
         sel_ff <= chosen;
         if (kind_ff) begin
            slot_off_ff[chosen] <= offset_ff;
            res_found_ff        <= hit_any;
            res_used_ff         <= slot_to_used(chosen);
         end else if (hit_any) begin
            res_found_ff <= 1'b1;
            res_off_ff   <= slot_off_ff[hit_idx];
            res_used_ff  <= slot_to_used(hit_idx);
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.name_ok    <= res_ok_ff;
         rsp_ff.found      <= res_found_ff;
         rsp_ff.offset_out <= res_off_ff;
         rsp_ff.slot_used  <= res_used_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
